// ===== src/msfir_pkg.sv =====
// ----------------------------------------------------------------------------
// msfir_pkg
// Shared constants, register codes and control structs for the multichannel
// symmetric FIR filter.
// ----------------------------------------------------------------------------
package msfir_pkg;

    localparam int MAX_TAPS     = 256;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 24;

    localparam int TAP_W      = $clog2(MAX_TAPS);
    localparam int CH_W       = $clog2(MAX_CHANNELS);
    localparam int CNT_W      = TAP_W + 1;
    localparam int ADDR_W     = CH_W + TAP_W;
    localparam int SUM_W      = SAMPLE_BITS + 1;
    localparam int PROD_W     = SUM_W + COEF_BITS;
    localparam int ACC_W      = PROD_W + TAP_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COEF_BITS;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP_COUNT   = 2'd0,
        REG_SYMMETRIC   = 2'd1,
        REG_COEF_SELECT = 2'd2,
        REG_COEF_WORD   = 2'd3
    } cfg_reg_t;

    // Filter setup seen by controller and datapath
    typedef struct packed {
        logic [CNT_W-1:0] taps;     // clamped to MAX_TAPS
        logic             sym;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             accept;
        logic             step_valid;
        logic [TAP_W-1:0] step_idx;
        logic             round;
        logic             load_out;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== src/msfir_cfg.sv =====
// ----------------------------------------------------------------------------
// msfir_cfg
// Configuration registers and the coefficient table with its valid bits.
// ----------------------------------------------------------------------------
module msfir_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [msfir_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msfir_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [msfir_pkg::TAP_W-1:0]          coef_raddr,
    output logic signed [msfir_pkg::COEF_BITS-1:0] coef_rdata,
    output msfir_pkg::cfg_t                      cfg
);
    import msfir_pkg::*;

    logic [CNT_W-1:0]            tap_count_reg;
    logic                        sym_reg;
    logic [TAP_W-1:0]            coef_sel_reg;
    logic [MAX_TAPS-1:0]         coef_vld_reg;
    logic signed [COEF_BITS-1:0] coef_mem [MAX_TAPS];
    logic signed [COEF_BITS-1:0] coef_rd_reg;
    logic                        coef_ok_reg;
    logic                        wr;
    logic                        coef_we;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;
    assign coef_we   = wr && (cfg_index == REG_COEF_WORD);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= CNT_W'(1);
            sym_reg       <= 1'b0;
            coef_sel_reg  <= '0;
            coef_vld_reg  <= '0;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                REG_TAP_COUNT:   tap_count_reg <= cfg_data[CNT_W-1:0];
                REG_SYMMETRIC:   sym_reg <= cfg_data[0];
                REG_COEF_SELECT: coef_sel_reg <= cfg_data[TAP_W-1:0];
                REG_COEF_WORD:   coef_vld_reg[coef_sel_reg] <= 1'b1;
                default:         ;
            endcase
        end
    end

    // Coefficient table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_sel_reg] <= cfg_data[COEF_BITS-1:0];
        end
        coef_rd_reg <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_ok_reg <= 1'b0;
        end
        else
        begin
            coef_ok_reg <= coef_vld_reg[coef_raddr];
        end
    end

    // Unwritten coefficients read as zero
    assign coef_rdata = coef_ok_reg ? coef_rd_reg : '0;

    assign cfg.taps = (tap_count_reg > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : tap_count_reg;
    assign cfg.sym  = sym_reg;

endmodule

// ===== src/msfir_ctrl.sv =====
// ----------------------------------------------------------------------------
// msfir_ctrl
// Sequencer: accepts a sample, steps the shared MAC over the taps, waits for
// the pipeline to drain, rounds and hands the result to the output register.
// ----------------------------------------------------------------------------
module msfir_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  msfir_pkg::cfg_t     cfg,
    input  msfir_pkg::dp_stat_t stat,
    output msfir_pkg::dp_cmd_t  cmd
);
    import msfir_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_FLUSH = 5'b00100,
        S_ROUND = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [TAP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] n_steps;
    logic [CNT_W:0]   taps_up;

    // Folded mode runs ceil(taps/2) steps
    assign taps_up = {1'b0, cfg.taps} + (CNT_W+1)'(1);
    assign n_steps = cfg.sym ? taps_up[CNT_W:1] : cfg.taps;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        in_ready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.step_valid = 1'b0;
        cmd.step_idx   = step_reg;
        cmd.round      = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    step_next  = '0;
                    state_next = (n_steps == '0) ? S_FLUSH : S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.step_valid = 1'b1;
                if ({1'b0, step_reg} == n_steps - CNT_W'(1))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    step_next = step_reg + TAP_W'(1);
                end
            end
            S_FLUSH:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== src/msfir_dp.sv =====
// ----------------------------------------------------------------------------
// msfir_dp
// Datapath: per-channel delay memory with fill counts, pre-add / multiply /
// accumulate pipeline, rounding with saturation and the output register.
// ----------------------------------------------------------------------------
module msfir_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  msfir_pkg::dp_cmd_t                     cmd,
    input  msfir_pkg::cfg_t                        cfg,
    input  logic [msfir_pkg::CH_W-1:0]             channel,
    input  logic signed [msfir_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   end_of_buffer,
    input  logic signed [msfir_pkg::COEF_BITS-1:0] coef_rdata,
    output msfir_pkg::dp_stat_t                    stat,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [msfir_pkg::CH_W-1:0]             channel_out,
    output logic signed [msfir_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                   end_of_buffer_out
);
    import msfir_pkg::*;

    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_BITS - 2);
    localparam logic signed [ACC_W-1:0] HI  = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] LO  = -HI - ACC_W'(1);

    // Per-channel write pointer and fill count
    logic [TAP_W-1:0]              wp_reg   [MAX_CHANNELS];
    logic [CNT_W-1:0]              fill_reg [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] dly_mem  [MAX_CHANNELS*MAX_TAPS];

    logic [CH_W-1:0]               ch_reg;
    logic                          eob_reg;
    logic [TAP_W-1:0]              wp_new;
    logic [CNT_W-1:0]              n2;
    logic [TAP_W-1:0]              off_a, off_b;
    logic                          a_ok, b_ok;

    logic                          va_reg, vb_reg, vp_reg;
    logic                          a_ok_reg, b_ok_reg;
    logic signed [SAMPLE_BITS-1:0] rd_a_reg, rd_b_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [COEF_BITS-1:0]   coef_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_rnd;
    logic signed [ACC_W-1:0]       acc_sh;
    logic signed [SAMPLE_BITS-1:0] res_reg;
    logic signed [SAMPLE_BITS-1:0] res_next;
    logic                          out_valid_reg;

    assign wp_new = wp_reg[channel] + TAP_W'(1);

    // Sample write and pointer update on input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                wp_reg[c]   <= '0;
                fill_reg[c] <= '0;
            end
        end
        else if (cmd.accept)
        begin
            wp_reg[channel] <= wp_new;
            if (fill_reg[channel] != CNT_W'(MAX_TAPS))
            begin
                fill_reg[channel] <= fill_reg[channel] + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ch_reg  <= channel;
            eob_reg <= end_of_buffer;
        end
    end

    // Tap addresses: delay i and mirror delay taps-1-i
    assign n2    = cfg.taps - CNT_W'(1) - {1'b0, cmd.step_idx};
    assign off_a = wp_reg[ch_reg] - cmd.step_idx;
    assign off_b = wp_reg[ch_reg] - n2[TAP_W-1:0];
    assign a_ok  = {1'b0, cmd.step_idx} < fill_reg[ch_reg];
    assign b_ok  = cfg.sym && ({1'b0, cmd.step_idx} < (cfg.taps >> 1))
                   && (n2 < fill_reg[ch_reg]);

    // Delay memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dly_mem[{channel, wp_new}] <= sample_in;
        end
        rd_a_reg <= dly_mem[{ch_reg, off_a}];
        rd_b_reg <= dly_mem[{ch_reg, off_b}];
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vp_reg   <= 1'b0;
            a_ok_reg <= 1'b0;
            b_ok_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= cmd.step_valid;
            vb_reg   <= va_reg;
            vp_reg   <= vb_reg;
            a_ok_reg <= a_ok;
            b_ok_reg <= b_ok;
        end
    end

    // Pre-add, multiply
    always_ff @(posedge clk)
    begin
        sum_reg  <= (a_ok_reg ? SUM_W'(rd_a_reg) : '0)
                  + (b_ok_reg ? SUM_W'(rd_b_reg) : '0);
        coef_reg <= coef_rdata;
        prod_reg <= PROD_W'(sum_reg) * PROD_W'(coef_reg);
    end

    // Accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            acc_reg <= '0;
        end
        else if (vp_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Round half up and saturate
    assign acc_rnd = acc_reg + RND;
    assign acc_sh  = acc_rnd >>> (COEF_BITS - 1);

    always_comb
    begin
        priority if (acc_sh > HI)
        begin
            res_next = HI[SAMPLE_BITS-1:0];
        end
        else if (acc_sh < LO)
        begin
            res_next = LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            res_next = acc_sh[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            res_reg <= res_next;
        end
        if (cmd.load_out)
        begin
            channel_out       <= ch_reg;
            sample_out        <= res_reg;
            end_of_buffer_out <= eob_reg;
        end
    end

    // Output register handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.pipe_busy = va_reg | vb_reg | vp_reg;

endmodule

// ===== src/multichannel_symmetric_fir_filter_top.sv =====
// Sequence: the single shared MAC steps one tap (pair) per cycle over N steps,
//   N = taps (or ceil(taps/2) in symmetric mode), then its four-stage pipeline
//   drains and the result is rounded and loaded into the output register.
// Flow: one sample at a time; a result may wait in the output register
//   while the next sample is filtered, and stalls emit.
// Reset: asynchronous, active low; delay lines and coefficients read as zero.
// ----------------------------------------------------------------------------
// multichannel_symmetric_fir_filter_top
// Eight-channel FIR filter with optional symmetric coefficient folding.
// ----------------------------------------------------------------------------
module multichannel_symmetric_fir_filter_top (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [msfir_pkg::CH_W-1:0]               channel,
    input  logic signed [msfir_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                     end_of_buffer,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [msfir_pkg::CH_W-1:0]               channel_out,
    output logic signed [msfir_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                     end_of_buffer_out,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [msfir_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [msfir_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import msfir_pkg::*;

    cfg_t                  cfg;
    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic signed [COEF_BITS-1:0] coef_rdata;

    msfir_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .coef_raddr (cmd.step_idx),
        .coef_rdata (coef_rdata),
        .cfg        (cfg)
    );

    msfir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cfg      (cfg),
        .stat     (stat),
        .cmd      (cmd)
    );

    msfir_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg),
        .channel           (channel),
        .sample_in         (sample_in),
        .end_of_buffer     (end_of_buffer),
        .coef_rdata        (coef_rdata),
        .stat              (stat),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .channel_out       (channel_out),
        .sample_out        (sample_out),
        .end_of_buffer_out (end_of_buffer_out)
    );

endmodule
